// ===== design/rics_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rics_pkg
// shared types, codes, fixed-point constants and small lookup functions
// ----------------------------------------------------------------------------
package rics_pkg;

  // integrand select codes
  localparam logic [1:0] ACT_SIN  = 2'd0;
  localparam logic [1:0] ACT_COS  = 2'd1;
  localparam logic [1:0] ACT_EXP  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // polynomial kinds
  localparam logic [1:0] POLY_SIN = 2'd0;
  localparam logic [1:0] POLY_COS = 2'd1;
  localparam logic [1:0] POLY_EXP = 2'd2;

  // rounding shift select for a fixed-point product
  localparam logic [1:0] RND_Q60  = 2'd0;
  localparam logic [1:0] RND_X    = 2'd1;
  localparam logic [1:0] RND_TERM = 2'd2;

  localparam int STEPS_W = 18;

  localparam logic signed [63:0] ONE_Q60     = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] HALF_Q56    = 64'sh0080_0000_0000_0000;
  localparam logic signed [63:0] PIO2_Q56    = 64'sh0192_1FB5_4442_D184;
  localparam logic signed [63:0] TWO_PI_Q60  = 64'sh0A2F_9836_E4E4_4153;
  localparam logic signed [63:0] LN2_Q56     = 64'sh00B1_7217_F7D1_CF7A;
  localparam logic signed [63:0] INV_LN2_Q60 = 64'sh1715_4765_2B82_FE17;
  localparam logic signed [63:0] VMAX        = 64'sh007F_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VMIN        = -64'sh0080_0000_0000_0000;
  localparam logic [64:0]        TWO_64      = 65'h1_0000_0000_0000_0000;

  typedef struct packed {
    logic                      none;
    logic [1:0]                act;
    logic signed [5:0]         lower;
    logic [STEPS_W-1:0]        steps;
  } cmd_ctl_t;

  typedef struct packed {
    logic                      overflow;
    logic signed [55:0]        value;
  } res_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // divisor of one horner step
  function automatic logic [7:0] poly_div(input logic [1:0] kind, input logic [3:0] j);
    logic [7:0] d;
    d = 8'd1;
    case (kind)
      POLY_SIN: begin
        case (j)
          4'd1: d = 8'd6;
          4'd2: d = 8'd20;
          4'd3: d = 8'd42;
          4'd4: d = 8'd72;
          4'd5: d = 8'd110;
          4'd6: d = 8'd156;
          4'd7: d = 8'd210;
          default: d = 8'd1;
        endcase
      end
      POLY_COS: begin
        case (j)
          4'd1: d = 8'd2;
          4'd2: d = 8'd12;
          4'd3: d = 8'd30;
          4'd4: d = 8'd56;
          4'd5: d = 8'd90;
          4'd6: d = 8'd132;
          4'd7: d = 8'd182;
          4'd8: d = 8'd240;
          default: d = 8'd1;
        endcase
      end
      default: d = 8'(j);
    endcase
    return d;
  endfunction

  // floor(2^64 / d)
  function automatic logic [63:0] poly_rcp(input logic [7:0] d);
    logic [63:0] r;
    r = 64'd0;
    case (d)
      8'd2:   r = 64'(TWO_64 / 65'd2);
      8'd3:   r = 64'(TWO_64 / 65'd3);
      8'd4:   r = 64'(TWO_64 / 65'd4);
      8'd5:   r = 64'(TWO_64 / 65'd5);
      8'd6:   r = 64'(TWO_64 / 65'd6);
      8'd7:   r = 64'(TWO_64 / 65'd7);
      8'd8:   r = 64'(TWO_64 / 65'd8);
      8'd9:   r = 64'(TWO_64 / 65'd9);
      8'd10:  r = 64'(TWO_64 / 65'd10);
      8'd11:  r = 64'(TWO_64 / 65'd11);
      8'd12:  r = 64'(TWO_64 / 65'd12);
      8'd20:  r = 64'(TWO_64 / 65'd20);
      8'd30:  r = 64'(TWO_64 / 65'd30);
      8'd42:  r = 64'(TWO_64 / 65'd42);
      8'd56:  r = 64'(TWO_64 / 65'd56);
      8'd72:  r = 64'(TWO_64 / 65'd72);
      8'd90:  r = 64'(TWO_64 / 65'd90);
      8'd110: r = 64'(TWO_64 / 65'd110);
      8'd132: r = 64'(TWO_64 / 65'd132);
      8'd156: r = 64'(TWO_64 / 65'd156);
      8'd182: r = 64'(TWO_64 / 65'd182);
      8'd210: r = 64'(TWO_64 / 65'd210);
      8'd240: r = 64'(TWO_64 / 65'd240);
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/riemann_integral_sin_cos_exp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riemann_integral_sin_cos_exp_core
// right-endpoint rectangle-rule integrator of sin, cos or exp in fixed point
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          lower_bound, upper_bound, action
//  result    empty / pop          integral_value, overflow
//  config    cfg_we               cfg_data (num_steps)
//
//  the front takes an item and computes the step width with a bit-serial divide
//  the back evaluates sin, cos or exp at every sample point on the shared
//  64x64 multiplier, which builds each product from 4 partial products
//  reset clears both queues and state machines, num_steps returns to 200000
//  a full result queue stalls the back only; the front keeps taking items
//  until the command queue between them fills
// ----------------------------------------------------------------------------
module riemann_integral_sin_cos_exp_core #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [5:0]  lower_bound,
  input  logic signed [5:0]  upper_bound,
  input  logic [1:0]         action,
  output logic               empty,
  input  logic               pop,
  output logic signed [55:0] integral_value,
  output logic               overflow,
  input  logic               cfg_we,
  input  logic [17:0]        cfg_data
);
  import rics_pkg::*;

  localparam int HW    = FRAC_BITS + 7;
  localparam int CMD_W = $bits(cmd_ctl_t) + HW;
  localparam int RES_W = $bits(res_t);

  // step count register
  logic [STEPS_W-1:0] num_steps;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_steps <= STEPS_W'(200000);
    end else if (cfg_we) begin
      num_steps <= cfg_data;
    end
  end

  // front to queue
  logic                 f_push;
  logic                 f_full;
  cmd_ctl_t             f_ctl;
  logic signed [HW-1:0] f_h;

  // queue to back
  logic                 b_empty;
  logic                 b_pop;
  logic [CMD_W-1:0]     b_cmd;
  cmd_ctl_t             b_ctl;
  logic signed [HW-1:0] b_h;

  // back to result queue
  logic                 r_push;
  logic                 r_full;
  res_t                 r_item;
  res_t                 out_item;

  rics_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .action      (action),
    .num_steps   (num_steps),
    .cmd_push    (f_push),
    .cmd_full    (f_full),
    .cmd_ctl     (f_ctl),
    .cmd_h       (f_h)
  );

  // command queue parts front and back
  rics_fifo #(.W(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_ctl, f_h}),
    .full  (f_full),
    .pop   (b_pop),
    .dout  (b_cmd),
    .empty (b_empty)
  );

  assign b_ctl = b_cmd[CMD_W-1:HW];
  assign b_h   = b_cmd[HW-1:0];

  rics_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (b_empty),
    .cmd_pop   (b_pop),
    .cmd_ctl   (b_ctl),
    .cmd_h     (b_h),
    .res_push  (r_push),
    .res_full  (r_full),
    .res       (r_item)
  );

  // result queue, head item is on the ports while empty is low
  rics_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_item),
    .full  (r_full),
    .pop   (pop),
    .dout  (out_item),
    .empty (empty)
  );

  assign integral_value = out_item.value;
  assign overflow       = out_item.overflow;
endmodule

// ===== design/rics_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rics_fifo
// small register queue, depth a power of two
// ----------------------------------------------------------------------------
module rics_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end
endmodule

// ===== design/rics_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rics_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
module rics_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   step;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_ext;

  // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
  assign a_half = step[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        prod <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step != 3'd4) begin
          pp    <= {32'd0, a_half} * {32'd0, b_half};
          pp_sh <= (step == 3'd0) ? 2'd0 : ((step == 3'd3) ? 2'd2 : 2'd1);
        end
        if (step != 3'd0) prod <= prod + pp_ext;
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/rics_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rics_front
// takes items, computes the step width by a bit-serial divide, queues commands
// ----------------------------------------------------------------------------
module rics_front #(
  parameter int FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [5:0]             lower_bound,
  input  logic signed [5:0]             upper_bound,
  input  logic [1:0]                    action,
  input  logic [rics_pkg::STEPS_W-1:0]  num_steps,
  output logic                          cmd_push,
  input  logic                          cmd_full,
  output rics_pkg::cmd_ctl_t            cmd_ctl,
  output logic signed [FRAC_BITS+6:0]   cmd_h
);
  import rics_pkg::*;

  localparam int DW = FRAC_BITS + 6;
  localparam int CW = $clog2(DW + 1);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_PUSH = 2'd2;

  logic [1:0]         st;
  logic               neg;
  logic [STEPS_W-1:0] rem;
  logic [DW-1:0]      quo;
  logic [CW-1:0]      cnt;
  logic               accept;
  logic signed [6:0]  diff;
  logic [5:0]         dmag;
  logic [STEPS_W:0]   rem_t;
  logic signed [DW:0] quo_s;

  assign full     = (st != FS_IDLE);
  assign accept   = push && !full;
  assign diff     = 7'(upper_bound) - 7'(lower_bound);
  assign dmag     = diff[6] ? 6'(-diff) : diff[5:0];
  assign rem_t    = {rem, quo[DW-1]};
  assign quo_s    = {1'b0, quo};
  assign cmd_h    = neg ? -quo_s : quo_s;
  assign cmd_push = (st == FS_PUSH) && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FS_IDLE;
    end else begin
      case (st)
        FS_IDLE: begin
          if (accept) begin
            cmd_ctl.none  <= (action == ACT_NONE);
            cmd_ctl.act   <= action;
            cmd_ctl.lower <= lower_bound;
            cmd_ctl.steps <= (num_steps == '0) ? STEPS_W'(1) : num_steps;
            neg <= diff[6];
            rem <= '0;
            quo <= {dmag, {FRAC_BITS{1'b0}}};
            cnt <= CW'(DW);
            st  <= (action == ACT_NONE) ? FS_PUSH : FS_DIV;
          end
        end
        FS_DIV: begin
          // one quotient bit a cycle
          if (rem_t >= {1'b0, cmd_ctl.steps}) begin
            rem <= STEPS_W'(rem_t - {1'b0, cmd_ctl.steps});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rem <= rem_t[STEPS_W-1:0];
            quo <= {quo[DW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) st <= FS_PUSH;
        end
        FS_PUSH: begin
          if (!cmd_full) st <= FS_IDLE;
        end
        default: st <= FS_IDLE;
      endcase
    end
  end
endmodule

// ===== design/rics_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rics_back
// walks the sample points, evaluates the integrand and accumulates the sum
// ----------------------------------------------------------------------------
module rics_back #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  rics_pkg::cmd_ctl_t          cmd_ctl,
  input  logic signed [FRAC_BITS+6:0] cmd_h,
  output logic                        res_push,
  input  logic                        res_full,
  output rics_pkg::res_t              res
);
  import rics_pkg::*;

  localparam int XW = FRAC_BITS + 7;
  localparam logic signed [8:0] SH_BASE = 9'(60 - FRAC_BITS);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_STEP   = 5'd1;
  localparam logic [4:0] S_K_ISS  = 5'd2;
  localparam logic [4:0] S_MWAIT  = 5'd3;
  localparam logic [4:0] S_RND    = 5'd4;
  localparam logic [4:0] S_K      = 5'd5;
  localparam logic [4:0] S_RED    = 5'd6;
  localparam logic [4:0] S_SQ_ISS = 5'd7;
  localparam logic [4:0] S_SQ     = 5'd8;
  localparam logic [4:0] S_P_ISS  = 5'd9;
  localparam logic [4:0] S_P_DIV  = 5'd10;
  localparam logic [4:0] S_P_COR  = 5'd11;
  localparam logic [4:0] S_P_UPD  = 5'd12;
  localparam logic [4:0] S_SV_ISS = 5'd13;
  localparam logic [4:0] S_SV     = 5'd14;
  localparam logic [4:0] S_FOUT   = 5'd15;
  localparam logic [4:0] S_EXP    = 5'd16;
  localparam logic [4:0] S_T_ISS  = 5'd17;
  localparam logic [4:0] S_T      = 5'd18;
  localparam logic [4:0] S_DONE   = 5'd19;

  logic [4:0]               st;
  logic [4:0]               ret;
  logic [1:0]               act;
  logic signed [XW-1:0]     h;
  logic [STEPS_W-1:0]       n;
  logic [STEPS_W-1:0]       i;
  logic signed [XW-1:0]     x;
  logic signed [55:0]       sum;
  logic                     ovf;
  logic signed [6:0]        k;
  logic signed [63:0]       r;
  logic signed [63:0]       r2;
  logic signed [63:0]       p;
  logic [3:0]               j;
  logic [1:0]               kind;
  logic                     qneg;
  logic signed [63:0]       qv;
  logic [63:0]              qm;
  logic                     qm_neg;
  logic [63:0]              qd;
  logic signed [55:0]       f;
  logic                     mul_start;
  logic [63:0]              ma;
  logic [63:0]              mb;
  logic                     mneg;
  logic [1:0]               msel;
  logic                     mul_done;
  logic [127:0]             prod;

  // shared multiplier
  rics_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (prod)
  );

  // rounding of the product, magnitude to nearest
  logic [127:0] rhalf;
  logic [127:0] rsum;
  logic [62:0]  rmag;
  always_comb begin
    case (msel)
      RND_Q60: rhalf = 128'd1 << 59;
      RND_X:   rhalf = 128'd1 << (FRAC_BITS + 3);
      default: rhalf = 128'd1 << (FRAC_BITS - 1);
    endcase
    rsum = prod + rhalf;
    case (msel)
      RND_Q60: rmag = rsum[122:60];
      RND_X:   rmag = rsum[FRAC_BITS+66:FRAC_BITS+4];
      default: rmag = rsum[FRAC_BITS+62:FRAC_BITS];
    endcase
  end

  logic signed [63:0] x64;
  logic signed [63:0] h64;
  logic signed [63:0] f64;
  logic signed [63:0] k64;
  logic signed [63:0] kc;
  logic signed [63:0] r_next;
  logic [1:0]         quad;
  logic signed [63:0] opd;
  logic [7:0]         d;
  logic [63:0]        q0;
  logic [63:0]        rem;
  logic signed [63:0] qs;
  logic signed [63:0] v;
  logic signed [63:0] vr;
  logic signed [63:0] tk;
  logic signed [63:0] s64;

  assign x64    = 64'(x);
  assign h64    = 64'(h);
  assign f64    = 64'(f);
  assign k64    = 64'(k);
  assign kc     = k64 * ((act == ACT_EXP) ? LN2_Q56 : PIO2_Q56);
  assign r_next = ((x64 <<< (56 - FRAC_BITS)) - kc) <<< 4;
  assign quad   = k[1:0] + {1'b0, (act == ACT_COS)};
  assign opd    = (kind == POLY_EXP) ? r : r2;
  assign d      = poly_div(kind, j);
  assign q0     = prod[127:64];
  assign rem    = qm - q0 * {56'd0, d};
  assign qs     = qm_neg ? -$signed(qd) : $signed(qd);
  assign v      = qneg ? -p : p;
  assign vr     = v + (64'sd1 <<< (59 - FRAC_BITS));
  assign tk     = qv + HALF_Q56;
  assign s64    = 64'(sum) + qv;

  // exp: scale by 2^k and round
  logic [63:0]       e;
  logic signed [8:0] sh;
  logic [5:0]        shc;
  logic [5:0]        lsh;
  logic [63:0]       ev;
  logic              esat;
  always_comb begin
    e    = p[63] ? 64'd0 : 64'(p);
    sh   = SH_BASE - 9'(k);
    shc  = (sh > 9'sd62) ? 6'd62 : sh[5:0];
    lsh  = 6'(-sh);
    esat = 1'b0;
    if (!sh[8] && (sh != 9'sd0)) begin
      ev = (e + (64'd1 << (shc - 6'd1))) >> shc;
    end else if ((lsh != 6'd0) && (e > (64'(VMAX) >> lsh))) begin
      ev   = 64'(VMAX);
      esat = 1'b1;
    end else begin
      ev = e << lsh;
    end
    if (ev > 64'(VMAX)) begin
      ev   = 64'(VMAX);
      esat = 1'b1;
    end
  end

  assign cmd_pop      = (st == S_IDLE) && !cmd_empty;
  assign res_push     = (st == S_DONE) && !res_full;
  assign res.overflow = ovf;
  assign res.value    = sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      mul_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      case (st)
        S_IDLE: begin
          if (!cmd_empty) begin
            act <= cmd_ctl.act;
            n   <= cmd_ctl.steps;
            h   <= cmd_h;
            x   <= XW'(cmd_ctl.lower) <<< FRAC_BITS;
            i   <= '0;
            sum <= '0;
            ovf <= 1'b0;
            st  <= cmd_ctl.none ? S_DONE : S_STEP;
          end
        end
        S_STEP: begin
          x  <= x + h;
          i  <= i + 1'b1;
          st <= S_K_ISS;
        end
        S_K_ISS: begin
          ma        <= mag64(x64);
          mb        <= 64'((act == ACT_EXP) ? INV_LN2_Q60 : TWO_PI_Q60);
          mneg      <= x64[63];
          msel      <= RND_X;
          mul_start <= 1'b1;
          ret       <= S_K;
          st        <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) st <= S_RND;
        end
        S_RND: begin
          qv <= mneg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
          st <= ret;
        end
        S_K: begin
          k  <= 7'(tk >>> 56);
          st <= S_RED;
        end
        S_RED: begin
          r <= r_next;
          p <= ONE_Q60;
          if (act == ACT_EXP) begin
            kind <= POLY_EXP;
            j    <= 4'd12;
            st   <= S_P_ISS;
          end else begin
            kind <= quad[0] ? POLY_COS : POLY_SIN;
            j    <= quad[0] ? 4'd8 : 4'd7;
            qneg <= quad[1];
            st   <= S_SQ_ISS;
          end
        end
        S_SQ_ISS: begin
          ma        <= mag64(r);
          mb        <= mag64(r);
          mneg      <= 1'b0;
          msel      <= RND_Q60;
          mul_start <= 1'b1;
          ret       <= S_SQ;
          st        <= S_MWAIT;
        end
        S_SQ: begin
          r2 <= qv;
          st <= S_P_ISS;
        end
        S_P_ISS: begin
          ma        <= mag64(opd);
          mb        <= mag64(p);
          mneg      <= opd[63] ^ p[63];
          msel      <= RND_Q60;
          mul_start <= 1'b1;
          ret       <= S_P_DIV;
          st        <= S_MWAIT;
        end
        S_P_DIV: begin
          qm     <= mag64(qv);
          qm_neg <= qv[63];
          if (d == 8'd1) begin
            qd <= mag64(qv);
            st <= S_P_UPD;
          end else begin
            // quotient by reciprocal, corrected below
            ma        <= mag64(qv);
            mb        <= poly_rcp(d);
            mul_start <= 1'b1;
            ret       <= S_P_COR;
            st        <= S_MWAIT;
          end
        end
        S_P_COR: begin
          qd <= (rem >= {56'd0, d}) ? q0 + 64'd1 : q0;
          st <= S_P_UPD;
        end
        S_P_UPD: begin
          p <= (kind == POLY_EXP) ? ONE_Q60 + qs : ONE_Q60 - qs;
          if (j == 4'd1) begin
            case (kind)
              POLY_SIN: st <= S_SV_ISS;
              POLY_COS: st <= S_FOUT;
              default:  st <= S_EXP;
            endcase
          end else begin
            j  <= j - 4'd1;
            st <= S_P_ISS;
          end
        end
        S_SV_ISS: begin
          ma        <= mag64(r);
          mb        <= mag64(p);
          mneg      <= r[63] ^ p[63];
          msel      <= RND_Q60;
          mul_start <= 1'b1;
          ret       <= S_SV;
          st        <= S_MWAIT;
        end
        S_SV: begin
          p  <= qv;
          st <= S_FOUT;
        end
        S_FOUT: begin
          f  <= 56'(vr >>> (60 - FRAC_BITS));
          st <= S_T_ISS;
        end
        S_EXP: begin
          f   <= 56'(ev);
          ovf <= ovf | esat;
          st  <= S_T_ISS;
        end
        S_T_ISS: begin
          ma        <= mag64(f64);
          mb        <= mag64(h64);
          mneg      <= f64[63] ^ h64[63];
          msel      <= RND_TERM;
          mul_start <= 1'b1;
          ret       <= S_T;
          st        <= S_MWAIT;
        end
        S_T: begin
          // clamp after every addition, overflow stays for the item
          if (s64 > VMAX) begin
            sum <= 56'(VMAX);
            ovf <= 1'b1;
          end else if (s64 < VMIN) begin
            sum <= 56'(VMIN);
            ovf <= 1'b1;
          end else begin
            sum <= 56'(s64);
          end
          st <= (i == n) ? S_DONE : S_STEP;
        end
        S_DONE: begin
          if (!res_full) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rectangle-rule integrator of sin, cos and exp
// ----------------------------------------------------------------------------
// items go in through a queue-like push/full port in random bursts, results
// are drained through empty/pop with a stalling pattern; every accepted item
// is compared field by field in order with its typed-in result or, if none,
// with a bit-exact fixed-point integrator in the bench. the step count
// register is moved through zero, small values and its top value between phases
// ----------------------------------------------------------------------------
module testbench;
  import rics_pkg::*;

  localparam int FB = 24;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic signed [5:0]  lower_bound;
  logic signed [5:0]  upper_bound;
  logic [1:0]         action;
  logic               empty;
  logic               pop;
  logic signed [55:0] integral_value;
  logic               overflow;
  logic               cfg_we;
  logic [17:0]        cfg_data;

  riemann_integral_sin_cos_exp_core #(.FRAC_BITS(FB)) u_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .lower_bound    (lower_bound),
    .upper_bound    (upper_bound),
    .action         (action),
    .empty          (empty),
    .pop            (pop),
    .integral_value (integral_value),
    .overflow       (overflow),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  // directed stimulus; has_known marks rows whose result is typed in
  typedef struct {
    logic signed [5:0] lo;
    logic signed [5:0] hi;
    logic [1:0]        act;
    bit                has_known;
    longint            known_val;
    bit                known_ovf;
  } vec_t;

  localparam longint SAT_HI = 64'sh007F_FFFF_FFFF_FFFF;

  vec_t vec_tbl[] = '{
    '{6'sd0,   6'sd0,   ACT_SIN,  1, 0, 0},        // equal limits
    '{6'sd5,   6'sd5,   ACT_EXP,  1, 0, 0},        // equal limits
    '{-6'sd32, 6'sd31,  ACT_NONE, 1, 0, 0},        // unused select
    '{6'sd30,  6'sd31,  ACT_EXP,  1, SAT_HI, 1},   // exp clipped at the top
    '{6'sd31,  6'sd30,  ACT_EXP,  1, -SAT_HI, 1},  // clipped exp, negative step
    '{6'sd0,   6'sd1,   ACT_SIN,  0, 0, 0},
    '{6'sd0,   6'sd1,   ACT_COS,  0, 0, 0},
    '{6'sd0,   6'sd1,   ACT_EXP,  0, 0, 0},
    '{-6'sd16, 6'sd16,  ACT_SIN,  0, 0, 0},
    '{-6'sd16, 6'sd16,  ACT_COS,  0, 0, 0},
    '{-6'sd16, 6'sd16,  ACT_EXP,  0, 0, 0},
    '{6'sd16,  -6'sd16, ACT_COS,  0, 0, 0},        // reversed limits
    '{-6'sd32, 6'sd31,  ACT_SIN,  0, 0, 0},        // limits outside -16..16
    '{6'sd31,  -6'sd32, ACT_COS,  0, 0, 0},
    '{-6'sd32, -6'sd31, ACT_EXP,  0, 0, 0},
    '{-6'sd1,  6'sd0,   ACT_EXP,  0, 0, 0}
  };

  res_t   pending_q[$];
  int     mismatches;
  longint steps_cur;   // bench copy of num_steps

  // a*b / 2^s with the magnitude rounded half away from zero
  function automatic longint mul_round(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0]  ua, ub, m;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p + (128'd1 << (s - 1));
    m   = 64'(p >> s);
    m[63] = 1'b0;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint trig_sample(longint x, bit want_cos);
    longint t, k, r, r2, ps, pc, sv, v;
    logic [1:0] q;
    t  = mul_round(x, TWO_PI_Q60, FB + 4);
    k  = (t + HALF_Q56) >>> 56;
    r  = (x * (64'sd1 <<< (56 - FB)) - k * PIO2_Q56) * 16;
    r2 = mul_round(r, r, 60);
    ps = ONE_Q60;
    pc = ONE_Q60;
    for (int j = 7; j >= 1; j--)
      ps = ONE_Q60 - mul_round(r2, ps, 60) / longint'((2 * j) * (2 * j + 1));
    sv = mul_round(r, ps, 60);
    for (int j = 8; j >= 1; j--)
      pc = ONE_Q60 - mul_round(r2, pc, 60) / longint'((2 * j - 1) * (2 * j));
    q = k[1:0] + (want_cos ? 2'd1 : 2'd0);
    case (q)
      2'd0: v = sv;
      2'd1: v = pc;
      2'd2: v = -sv;
      default: v = -pc;
    endcase
    return (v + (64'sd1 <<< (59 - FB))) >>> (60 - FB);
  endfunction

  function automatic longint exp_sample(longint x, inout bit sat);
    longint t, k, r, e, sh, m;
    logic [63:0] v;
    t = mul_round(x, INV_LN2_Q60, FB + 4);
    k = (t + HALF_Q56) >>> 56;
    r = (x * (64'sd1 <<< (56 - FB)) - k * LN2_Q56) * 16;
    e = ONE_Q60;
    for (int j = 12; j >= 1; j--)
      e = ONE_Q60 + mul_round(r, e, 60) / longint'(j);
    if (e < 0) e = 0;
    sh = (60 - FB) - k;
    if (sh >= 1) begin
      if (sh > 62) sh = 62;
      v = (64'(e) + (64'd1 << (sh - 1))) >> sh;
    end else begin
      m = -sh;
      if (m > 0 && e > (SAT_HI >>> m)) begin
        sat = 1;
        return SAT_HI;
      end
      v = 64'(e) << m;
    end
    if (longint'(v) > SAT_HI) begin
      sat = 1;
      return SAT_HI;
    end
    return longint'(v);
  endfunction

  // full rectangle-rule sum for one item at the current step count
  function automatic res_t integrate(logic signed [5:0] lo, logic signed [5:0] hi,
                                     logic [1:0] act);
    res_t   res;
    longint n, h, x, f, acc;
    bit     sat;
    res = '0;
    if (act == ACT_NONE) return res;
    n   = (steps_cur == 0) ? 1 : steps_cur;
    h   = ((longint'(hi) - longint'(lo)) * (64'sd1 <<< FB)) / n;
    x   = longint'(lo) * (64'sd1 <<< FB);
    acc = 0;
    sat = 0;
    for (longint i = 1; i <= n; i++) begin
      x = x + h;
      if (act == ACT_SIN)      f = trig_sample(x, 0);
      else if (act == ACT_COS) f = trig_sample(x, 1);
      else                     f = exp_sample(x, sat);
      acc = acc + mul_round(f, h, FB);
      if (acc > SAT_HI) begin
        acc = SAT_HI;
        sat = 1;
      end else if (acc < VMIN) begin
        acc = VMIN;
        sat = 1;
      end
    end
    res.value    = 56'(acc);
    res.overflow = sat;
    return res;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  // result side: stall pattern changes now and then, with stretches of no stall
  initial begin
    int mode, left;
    pop = 0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(5, 60);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // result checker, in order against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%0d ovf=%0b", integral_value, overflow);
      end else begin
        want = pending_q.pop_front();
        if (integral_value !== want.value || overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%0d ovf=%0b, got value=%0d ovf=%0b",
                     want.value, want.overflow, integral_value, overflow);
        end
      end
    end
  end

  int burst_left;

  // one item through push/full, bursts with random gaps between them
  task automatic send_item(logic signed [5:0] lo, logic signed [5:0] hi, logic [1:0] act,
                           bit has_known, longint known_val, bit known_ovf);
    res_t want;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    if (has_known) begin
      want.value    = 56'(known_val);
      want.overflow = known_ovf;
    end else begin
      want = integrate(lo, hi, act);
    end
    push        <= 1'b1;
    lower_bound <= lo;
    upper_bound <= hi;
    action      <= act;
    do @(posedge clk); while (full);
    pending_q.push_back(want);
  endtask

  // drain, then let the back end settle before touching the register
  task automatic settle;
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (FB + 40) @(posedge clk);
  endtask

  task automatic write_steps(logic [17:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    steps_cur = v;
  endtask

  initial begin
    logic signed [5:0] lo, hi;
    int nphase;
    mismatches  = 0;
    burst_left  = 0;
    steps_cur   = 200000;
    rst         = 1;
    push        = 0;
    lower_bound = '0;
    upper_bound = '0;
    action      = ACT_SIN;
    cfg_we      = 0;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step count after reset is 200000: only the unused select is affordable
    send_item(6'sd3, -6'sd7, ACT_NONE, 1, 0, 0);
    send_item(-6'sd32, 6'sd31, ACT_NONE, 1, 0, 0);
    settle();

    // zero step count behaves as one step
    write_steps(18'd0);
    foreach (vec_tbl[i])
      send_item(vec_tbl[i].lo, vec_tbl[i].hi, vec_tbl[i].act,
                vec_tbl[i].has_known, vec_tbl[i].known_val, vec_tbl[i].known_ovf);
    settle();

    // top step count, unused select only
    write_steps(18'h3FFFF);
    send_item(-6'sd16, 6'sd16, ACT_NONE, 1, 0, 0);
    settle();

    // random phases at small step counts
    nphase = 0;
    repeat (8) begin
      if (nphase == 0)      write_steps(18'd1);
      else if (nphase == 1) write_steps(18'd2);
      else                  write_steps(18'($urandom_range(1, 16)));
      repeat (12) begin
        if ($urandom_range(0, 4) == 0) begin
          lo = 6'($urandom);
          hi = 6'($urandom);
        end else begin
          lo = 6'($urandom_range(0, 32) - 16);
          hi = 6'($urandom_range(0, 32) - 16);
        end
        send_item(lo, hi, 2'($urandom), 0, 0, 0);
      end
      settle();
      nphase++;
    end

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
